// ===== rtl/ngt_pkg.sv =====
package ngt_pkg;

  localparam int CHAR_W         = 21;
  localparam int WIN            = 4;
  localparam int MAX_GRAM_LIMIT = 4;
  localparam int GRAM_CAP       = (MAX_GRAM_LIMIT < WIN) ? MAX_GRAM_LIMIT : WIN;
  localparam int LEN_W          = 3;
  localparam int OFF_W          = 32;
  localparam int START_W        = 32;
  localparam int QDEPTH         = 2;
  localparam int QAW            = $clog2(QDEPTH);
  localparam int IN_TDATA_W     = 24;
  localparam int OUT_TDATA_W    = 120;
  localparam int CFG_AW         = 1;

  localparam logic [CFG_AW-1:0] REG_MIN_GRAM = 1'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_GRAM = 1'd1;

  localparam logic [LEN_W-1:0] MIN_GRAM_RST = 3'd2;
  localparam logic [LEN_W-1:0] MAX_GRAM_RST = 3'd4;

  typedef logic [CHAR_W-1:0] char_t;

  // One queued item: the window after the shift and the plan for its grams.
  typedef struct packed {
    char_t [WIN-1:0]  win;
    logic [LEN_W-1:0] a0;
    logic [LEN_W-1:0] mn;
    logic             eot;
    logic             has;
    logic [OFF_W-1:0] p1;
  } ngt_job_t;

  function automatic char_t fold(input char_t c);
    if (c >= 21'h41 && c <= 21'h5A) begin
      return c + 21'h20;
    end
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    if (v == '0) begin
      return LEN_W'(1);
    end
    if (v > LEN_W'(GRAM_CAP)) begin
      return LEN_W'(GRAM_CAP);
    end
    return v;
  endfunction

endpackage

// ===== rtl/ngt_front.sv =====
module ngt_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ngt_pkg::char_t             char_i,
  input  logic                       eot_i,
  input  logic                       cfg_valid_i,
  input  logic [ngt_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [ngt_pkg::LEN_W-1:0]  cfg_data_i,
  input  logic                       full_i,
  output logic                       push_o,
  output ngt_pkg::ngt_job_t          job_o
);
  import ngt_pkg::*;

  logic [LEN_W-1:0] min_q, max_q;
  char_t [WIN-1:0]  win_q, win_n;
  logic [LEN_W-1:0] fill_q, fill_n;
  logic [OFF_W-1:0] off_q;
  logic [LEN_W-1:0] cmin, cmax, mn, mx;
  logic             accept, full_set;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_GRAM_RST;
      max_q <= MAX_GRAM_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_MIN_GRAM: min_q <= cfg_data_i;
        REG_MAX_GRAM: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmin = clamp_len(min_q);
    cmax = clamp_len(max_q);
    mn   = (cmin > cmax) ? cmax : cmin;
    mx   = (cmin > cmax) ? cmin : cmax;
    for (int i = 0; i < WIN - 1; i++) begin
      win_n[i] = win_q[i + 1];
    end
    win_n[WIN-1] = fold(char_i);
    fill_n   = (fill_q < LEN_W'(GRAM_CAP)) ? fill_q + LEN_W'(1) : fill_q;
    full_set = (fill_n >= mx);
  end

  always_comb begin
    job_o.win = win_n;
    job_o.a0  = full_set ? mx : fill_n;
    job_o.mn  = mn;
    job_o.eot = eot_i;
    job_o.has = (full_set | eot_i) & (job_o.a0 >= mn);
    job_o.p1  = off_q + OFF_W'(1);
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
      off_q  <= '0;
    end else if (accept) begin
      if (eot_i) begin
        win_q  <= '0;
        fill_q <= '0;
        off_q  <= '0;
      end else begin
        win_q  <= win_n;
        fill_q <= fill_n;
        off_q  <= off_q + OFF_W'(1);
      end
    end
  end

endmodule

// ===== rtl/ngt_fifo.sv =====
module ngt_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ngt_pkg::ngt_job_t data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output ngt_pkg::ngt_job_t head_o
);
  import ngt_pkg::*;

  ngt_job_t       mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;

  assign full_o  = (cnt_q == (QAW + 1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + QAW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QAW + 1)'(1);
        2'b01:   cnt_q <= cnt_q - (QAW + 1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/ngt_back.sv =====
module ngt_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            empty_i,
  input  ngt_pkg::ngt_job_t               head_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ngt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import ngt_pkg::*;

  logic                   started_q;
  logic [LEN_W-1:0]       a_q, l_q, cur_a, cur_l;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] data_q;
  logic                   user_q, last_q;
  logic                   can_load, emit, skip, last;
  char_t [WIN-1:0]        chars;
  logic [LEN_W-1:0]       base, idx;
  logic [OFF_W-1:0]       start;

  assign can_load = ~out_valid_q | m_axis_tready;
  assign cur_a    = started_q ? a_q : head_i.a0;
  assign cur_l    = started_q ? l_q : head_i.mn;
  assign emit     = ~empty_i & head_i.has & can_load;
  assign skip     = ~empty_i & ~head_i.has;
  // The item is done after its longest gram when no shorter trailing set follows.
  assign last     = (cur_l == cur_a) & (~head_i.eot | (cur_a <= head_i.mn));
  assign pop_o    = skip | (emit & last);
  assign start    = head_i.p1 - OFF_W'(cur_a);
  assign base     = LEN_W'(WIN) - cur_a;

  always_comb begin
    idx = '0;
    for (int i = 0; i < WIN; i++) begin
      idx      = base + LEN_W'(i);
      chars[i] = (LEN_W'(i) < cur_l) ? head_i.win[idx[1:0]] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      a_q       <= '0;
      l_q       <= '0;
    end else if (emit) begin
      if (last) begin
        started_q <= 1'b0;
      end else if (cur_l == cur_a) begin
        started_q <= 1'b1;
        a_q       <= cur_a - LEN_W'(1);
        l_q       <= head_i.mn;
      end else begin
        started_q <= 1'b1;
        a_q       <= cur_a;
        l_q       <= cur_l + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (can_load) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      data_q <= {1'b0, START_W'(start), cur_l, chars[3], chars[2], chars[1], chars[0]};
      user_q <= (cur_l == head_i.mn);
      last_q <= last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tlast  = last_q;

`ifndef ASSERT_OFF
  a_started_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> (!empty_i && head_i.has))
    else $error("gram sequencer mid-item with no item at the queue head");

  a_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (cur_l >= head_i.mn && cur_l <= cur_a && cur_a <= LEN_W'(GRAM_CAP)))
    else $error("gram length outside the current set");

  a_skip_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip |-> !started_q)
    else $error("item without grams dropped while sequencer busy");
`endif

endmodule

// ===== rtl/char_ngram_tokenizer.sv =====
// Character n-gram tokenizer.
// Input stream: one code point per transaction in s_axis_tdata, with
// s_axis_tlast on the final character of a text. Output stream: one n-gram
// per transaction, all grams at an offset shortest first; m_axis_tlast marks
// the final gram caused by one input character.
// Configuration: cfg_addr_i 0 is min_gram, 1 is max_gram (3 bits each);
// write only while the block is idle. cfg_ready_o is always high.
// The back end issues one gram per cycle while the receiver accepts them;
// a character yields max_gram - min_gram + 1 grams in steady state and up
// to ten on the last character of a text, and a character that yields none
// is dropped from the queue head. A two-entry queue between the front and
// the gram sequencer lets new characters in while grams are still going out.
// Reset clears the window, the offset counter and all queued work, and sets
// min_gram to 2 and max_gram to 4. When the receiver stalls, the output
// register holds its gram, the queue fills and s_axis_tready drops.
module char_ngram_tokenizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [20:0] char_code
  input  logic [ngt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [20:0] gram_char_0, [41:21] gram_char_1, [62:42] gram_char_2,
  // [83:63] gram_char_3, [86:84] gram_length, [118:87] start_offset
  output logic [ngt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] position_increment
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ngt_pkg::CFG_AW-1:0]      cfg_addr_i,
  input  logic [ngt_pkg::LEN_W-1:0]       cfg_data_i
);
  import ngt_pkg::*;

  logic     push, pop, full, empty;
  ngt_job_t job, head;

  assign cfg_ready_o = 1'b1;

  ngt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .char_i      (s_axis_tdata[CHAR_W-1:0]),
    .eot_i       (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job)
  );

  ngt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  ngt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
